FILE: src/sbht_pkg.sv
// Shared definitions for the segment/box hit test pipeline.
// Region code bits, edge and corner indices, and the classify result struct.
// No dependencies.
package sbht_pkg;

  localparam int COORD_BITS_DEF = 16;

  localparam logic [3:0] CODE_LEFT  = 4'd1;
  localparam logic [3:0] CODE_RIGHT = 4'd2;
  localparam logic [3:0] CODE_BELOW = 4'd4;
  localparam logic [3:0] CODE_ABOVE = 4'd8;
  localparam logic [3:0] CODE_LR    = CODE_LEFT | CODE_RIGHT;
  localparam logic [3:0] CODE_BA    = CODE_BELOW | CODE_ABOVE;

  // Box edges.
  localparam int EDGE_LEFT   = 0;
  localparam int EDGE_RIGHT  = 1;
  localparam int EDGE_BOTTOM = 2;
  localparam int EDGE_TOP    = 3;

  // Box corners, named by (x, y) as low or high.
  localparam int CORNER_LL = 0;
  localparam int CORNER_LH = 1;
  localparam int CORNER_HL = 2;
  localparam int CORNER_HH = 3;

  typedef struct packed {
    logic [3:0] start_region;
    logic [3:0] end_region;
    logic       rejected;
    logic       quick_hit;
    logic [3:0] edge_ok;
  } class_t;

endpackage

FILE: src/sbht_classify.sv
// Front-end classification: region codes, trivial reject and accept, and the
// per-edge extent and edge-side checks that need no products. Uses sbht_pkg.
module sbht_classify #(
  parameter int COORD_BITS = sbht_pkg::COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] box_min_x,
  input  logic signed [COORD_BITS-1:0] box_min_y,
  input  logic signed [COORD_BITS-1:0] box_max_x,
  input  logic signed [COORD_BITS-1:0] box_max_y,
  input  logic signed [COORD_BITS-1:0] seg_start_x,
  input  logic signed [COORD_BITS-1:0] seg_start_y,
  input  logic signed [COORD_BITS-1:0] seg_end_x,
  input  logic signed [COORD_BITS-1:0] seg_end_y,
  output sbht_pkg::class_t             cls
);
  import sbht_pkg::*;

  logic signed [COORD_BITS-1:0] seg_lo_x, seg_hi_x, seg_lo_y, seg_hi_y;
  logic signed [COORD_BITS-1:0] box_lo_x, box_hi_x, box_lo_y, box_hi_y;
  logic [3:0] cs, ce, cor;
  logic       left_same, right_same, bottom_same, top_same;
  logic       span_y_vert, span_x_horz;

  always_comb begin
    seg_lo_x = (seg_start_x < seg_end_x) ? seg_start_x : seg_end_x;
    seg_hi_x = (seg_start_x < seg_end_x) ? seg_end_x : seg_start_x;
    seg_lo_y = (seg_start_y < seg_end_y) ? seg_start_y : seg_end_y;
    seg_hi_y = (seg_start_y < seg_end_y) ? seg_end_y : seg_start_y;
    // The box may be given inverted, so its extents are sorted too.
    box_lo_x = (box_min_x < box_max_x) ? box_min_x : box_max_x;
    box_hi_x = (box_min_x < box_max_x) ? box_max_x : box_min_x;
    box_lo_y = (box_min_y < box_max_y) ? box_min_y : box_max_y;
    box_hi_y = (box_min_y < box_max_y) ? box_max_y : box_min_y;

    cs = 4'd0;
    if (seg_start_x < box_min_x) cs = cs | CODE_LEFT;
    if (seg_start_x > box_max_x) cs = cs | CODE_RIGHT;
    if (seg_start_y < box_min_y) cs = cs | CODE_BELOW;
    if (seg_start_y > box_max_y) cs = cs | CODE_ABOVE;
    ce = 4'd0;
    if (seg_end_x < box_min_x) ce = ce | CODE_LEFT;
    if (seg_end_x > box_max_x) ce = ce | CODE_RIGHT;
    if (seg_end_y < box_min_y) ce = ce | CODE_BELOW;
    if (seg_end_y > box_max_y) ce = ce | CODE_ABOVE;
    cor = cs | ce;

    // Both endpoints strictly on one side of an edge line. This only rejects
    // when the edge has nonzero length, since a point edge has zero area.
    left_same   = ((seg_start_x > box_min_x) && (seg_end_x > box_min_x)) ||
                  ((seg_start_x < box_min_x) && (seg_end_x < box_min_x));
    right_same  = ((seg_start_x > box_max_x) && (seg_end_x > box_max_x)) ||
                  ((seg_start_x < box_max_x) && (seg_end_x < box_max_x));
    bottom_same = ((seg_start_y > box_min_y) && (seg_end_y > box_min_y)) ||
                  ((seg_start_y < box_min_y) && (seg_end_y < box_min_y));
    top_same    = ((seg_start_y > box_max_y) && (seg_end_y > box_max_y)) ||
                  ((seg_start_y < box_max_y) && (seg_end_y < box_max_y));

    span_y_vert = (box_lo_y <= seg_hi_y) && (seg_lo_y <= box_hi_y);
    span_x_horz = (box_lo_x <= seg_hi_x) && (seg_lo_x <= box_hi_x);

    cls.start_region = cs;
    cls.end_region   = ce;
    cls.rejected     = |(cs & ce);
    cls.quick_hit    = (cs == 4'd0) || (ce == 4'd0) || (cor == CODE_LR) || (cor == CODE_BA);
    cls.edge_ok[EDGE_LEFT]   = (seg_lo_x <= box_min_x) && (box_min_x <= seg_hi_x) &&
                               span_y_vert && !((box_max_y != box_min_y) && left_same);
    cls.edge_ok[EDGE_RIGHT]  = (seg_lo_x <= box_max_x) && (box_max_x <= seg_hi_x) &&
                               span_y_vert && !((box_max_y != box_min_y) && right_same);
    cls.edge_ok[EDGE_BOTTOM] = (seg_lo_y <= box_min_y) && (box_min_y <= seg_hi_y) &&
                               span_x_horz && !((box_max_x != box_min_x) && bottom_same);
    cls.edge_ok[EDGE_TOP]    = (seg_lo_y <= box_max_y) && (box_max_y <= seg_hi_y) &&
                               span_x_horz && !((box_max_x != box_min_x) && top_same);
  end

endmodule

FILE: src/segment_box_hit_test.sv
// Segment against axis-aligned box hit test, four-stage pipeline.
// Depends on sbht_pkg and sbht_classify.
//
// Usage: present a box and a segment on the input channel (in_valid and
// in_ready); one result item (hit, both region codes, trivial reject flag)
// comes out on the output channel (out_valid and out_ready) per input item,
// in order.
// Throughput is one item per cycle while the output is not stalled: the four
// register stages are region classification, four signed products of the segment
// direction with the corner offsets, the corner area signs, and the final edge
// combine into the output register.
// Each stage holds its item until the next stage can take it, so a stalled
// receiver backs the pipeline up one stage at a time; empty stages keep
// accepting, and in_ready drops only once every stage is full.
// Reset clears all stage valid bits; no item is in flight afterward.
// Box extents may be inverted; coordinates are used exactly as given.
module segment_box_hit_test #(
  parameter int COORD_BITS = sbht_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] box_min_x,
  input  logic signed [COORD_BITS-1:0] box_min_y,
  input  logic signed [COORD_BITS-1:0] box_max_x,
  input  logic signed [COORD_BITS-1:0] box_max_y,
  input  logic signed [COORD_BITS-1:0] seg_start_x,
  input  logic signed [COORD_BITS-1:0] seg_start_y,
  input  logic signed [COORD_BITS-1:0] seg_end_x,
  input  logic signed [COORD_BITS-1:0] seg_end_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic [3:0]                   start_region,
  output logic [3:0]                   end_region,
  output logic                         trivially_rejected
);
  import sbht_pkg::*;

  localparam int W1 = COORD_BITS + 1;
  localparam int WP = 2 * W1;
  localparam int WD = WP + 1;

  class_t cls_next;

  // Stage A: classification and coordinate differences.
  logic              va;
  class_t            cls_a;
  logic signed [W1-1:0] dx, dy, off_lx, off_hx, off_ly, off_hy;
  // Stage B: products.
  logic              vb;
  class_t            cls_b;
  logic signed [WP-1:0] p_ly, p_hy, q_lx, q_hx;
  // Stage C: corner area signs.
  logic              vc;
  class_t            cls_c;
  logic [3:0]        corner_pos, corner_neg;
  logic signed [WD-1:0] area_ll, area_lh, area_hl, area_hh;
  // Stage D combine.
  logic [3:0]        cross_rej;
  logic              hit_next;

  logic ra, rb, rc, rd;

  sbht_classify #(.COORD_BITS(COORD_BITS)) u_classify (
    .box_min_x  (box_min_x),
    .box_min_y  (box_min_y),
    .box_max_x  (box_max_x),
    .box_max_y  (box_max_y),
    .seg_start_x(seg_start_x),
    .seg_start_y(seg_start_y),
    .seg_end_x  (seg_end_x),
    .seg_end_y  (seg_end_y),
    .cls        (cls_next)
  );

  assign rd       = !out_valid || out_ready;
  assign rc       = !vc || rd;
  assign rb       = !vb || rc;
  assign ra       = !va || rb;
  assign in_ready = ra;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ra) begin
      va <= in_valid;
    end
    if (ra) begin
      cls_a  <= cls_next;
      dx     <= W1'(seg_end_x) - W1'(seg_start_x);
      dy     <= W1'(seg_end_y) - W1'(seg_start_y);
      off_lx <= W1'(box_min_x) - W1'(seg_start_x);
      off_hx <= W1'(box_max_x) - W1'(seg_start_x);
      off_ly <= W1'(box_min_y) - W1'(seg_start_y);
      off_hy <= W1'(box_max_y) - W1'(seg_start_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rb) begin
      vb <= va;
    end
    if (rb) begin
      cls_b <= cls_a;
      p_ly  <= WP'(dx) * WP'(off_ly);
      p_hy  <= WP'(dx) * WP'(off_hy);
      q_lx  <= WP'(dy) * WP'(off_lx);
      q_hx  <= WP'(dy) * WP'(off_hx);
    end
  end

  // Cross product of the segment direction with each corner offset.
  always_comb begin
    area_ll = WD'(p_ly) - WD'(q_lx);
    area_lh = WD'(p_hy) - WD'(q_lx);
    area_hl = WD'(p_ly) - WD'(q_hx);
    area_hh = WD'(p_hy) - WD'(q_hx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (rc) begin
      vc <= vb;
    end
    if (rc) begin
      cls_c <= cls_b;
      corner_neg[CORNER_LL] <= area_ll[WD-1];
      corner_neg[CORNER_LH] <= area_lh[WD-1];
      corner_neg[CORNER_HL] <= area_hl[WD-1];
      corner_neg[CORNER_HH] <= area_hh[WD-1];
      corner_pos[CORNER_LL] <= !area_ll[WD-1] && (area_ll != '0);
      corner_pos[CORNER_LH] <= !area_lh[WD-1] && (area_lh != '0);
      corner_pos[CORNER_HL] <= !area_hl[WD-1] && (area_hl != '0);
      corner_pos[CORNER_HH] <= !area_hh[WD-1] && (area_hh != '0);
    end
  end

  // An edge is missed when both of its corners lie strictly on one side of
  // the segment's line.
  always_comb begin
    cross_rej[EDGE_LEFT] =
      (corner_pos[CORNER_LL] && corner_pos[CORNER_LH]) ||
      (corner_neg[CORNER_LL] && corner_neg[CORNER_LH]);
    cross_rej[EDGE_RIGHT] =
      (corner_pos[CORNER_HL] && corner_pos[CORNER_HH]) ||
      (corner_neg[CORNER_HL] && corner_neg[CORNER_HH]);
    cross_rej[EDGE_BOTTOM] =
      (corner_pos[CORNER_LL] && corner_pos[CORNER_HL]) ||
      (corner_neg[CORNER_LL] && corner_neg[CORNER_HL]);
    cross_rej[EDGE_TOP] =
      (corner_pos[CORNER_LH] && corner_pos[CORNER_HH]) ||
      (corner_neg[CORNER_LH] && corner_neg[CORNER_HH]);
    hit_next = !cls_c.rejected &&
               (cls_c.quick_hit || (|(cls_c.edge_ok & ~cross_rej)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd) begin
      out_valid <= vc;
    end
    if (rd) begin
      hit                <= hit_next;
      start_region       <= cls_c.start_region;
      end_region         <= cls_c.end_region;
      trivially_rejected <= cls_c.rejected;
    end
  end

  a_rej_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && trivially_rejected |-> !hit)
    else $error("rejected item reported as hit");

  a_inside_hits: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((start_region == 4'd0) || (end_region == 4'd0)) |-> hit)
    else $error("endpoint inside box but no hit");

  a_rej_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (trivially_rejected == (|(start_region & end_region))))
    else $error("reject flag disagrees with region codes");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !va && !vb && !vc)
    else $error("pipeline not empty after reset");

endmodule
